[hdl/ffca_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the cluster allocator.
package ffca_pkg;

    localparam int UNIT_COUNT = 5120;
    localparam int UNIT_AW    = $clog2(UNIT_COUNT);
    localparam int UNIT_CW    = $clog2(UNIT_COUNT + 1);
    localparam int BYTE_W     = 15;
    localparam int NEED_W     = BYTE_W - 1;
    localparam int CMP_W      = (UNIT_CW > NEED_W) ? UNIT_CW : NEED_W;
    localparam int CFG_AW     = 3;
    localparam int CFG_DW     = 32;

    localparam logic [BYTE_W-1:0] ONE_UNIT_MAX = BYTE_W'(4);
    localparam logic [BYTE_W-1:0] HEAP_END_RST = BYTE_W'(20480);

    typedef enum logic [1:0] {
        CODE_FREE = 2'd0,
        CODE_CONT = 2'd1,
        CODE_END  = 2'd2,
        CODE_RSVD = 2'd3
    } t_code;

    typedef enum logic [1:0] {
        ACT_INIT  = 2'd0,
        ACT_ALLOC = 2'd1,
        ACT_FREE  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_NOSPACE  = 3'd1,
        STAT_BADINIT  = 3'd2,
        STAT_NOTALLOC = 3'd3,
        STAT_UNTERM   = 3'd4,
        STAT_HALTED   = 3'd5
    } t_status;

    typedef enum logic {
        REG_HEAP_START = 1'b0,
        REG_HEAP_END   = 1'b1
    } t_reg;

    typedef struct packed {
        logic    load;
        logic    clear_wr;
        logic    init_wr;
        logic    scan;
        logic    mark;
        logic    free_wr;
        logic    set_halt;
        logic    set_res;
        t_status res_code;
        logic    res_addr;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic  halted;
        logic  bad_init;
        logic  free_oob;
        logic  idx_last;
        logic  hit;
        logic  scan_end;
        logic  mark_last;
        t_code rd_code;
        logic  out_free;
    } t_dp_stat;

endpackage

[hdl/ffca_datapath.sv]
// Unit code table, scan counters, result and output registers of the cluster allocator.
module ffca_datapath import ffca_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  logic [1:0]        i_action,
    input  logic [BYTE_W-1:0] i_request_bytes,
    input  logic [BYTE_W-1:0] i_free_address,
    input  logic [BYTE_W-1:0] i_heap_start,
    input  logic [BYTE_W-1:0] i_heap_end,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [2:0]        o_status,
    output logic [BYTE_W-1:0] o_block_address
);

    logic [1:0]         r_mem [UNIT_COUNT];
    logic [1:0]         r_rdata;
    logic [UNIT_CW-1:0] r_idx;
    logic [UNIT_AW-1:0] r_pidx;
    logic               r_pend;
    logic [UNIT_CW-1:0] r_run;
    logic [UNIT_AW-1:0] r_start;
    logic [UNIT_AW-1:0] r_last;
    logic [CMP_W-1:0]   r_need;
    logic               r_halted;
    t_status            r_res_status;
    logic [BYTE_W-1:0]  r_res_addr;
    logic               r_out_vld;
    logic [2:0]         r_out_status;
    logic [BYTE_W-1:0]  r_out_addr;

    logic [BYTE_W:0]    w_start_sum;
    logic [BYTE_W:0]    w_end_sum;
    logic [BYTE_W:0]    w_req_sum;
    logic [CMP_W-1:0]   w_start_units;
    logic [CMP_W-1:0]   w_end_units;
    logic [CMP_W-1:0]   w_need;
    logic [CMP_W-1:0]   w_free_unit;
    logic [CMP_W-1:0]   w_idx_ext;
    logic [CMP_W-1:0]   w_run_inc;
    logic               w_issue_done;
    logic               w_free_seen;
    logic               w_hit;
    logic [UNIT_AW-1:0] w_hit_start;
    logic               w_mark_last;
    t_code              w_rd_code;
    t_code              w_init_code;
    logic               w_we;
    t_code              w_wdata;

    assign w_start_sum   = {1'b0, i_heap_start} + (BYTE_W + 1)'(3);
    assign w_end_sum     = {1'b0, i_heap_end} + (BYTE_W + 1)'(3);
    assign w_req_sum     = {1'b0, i_request_bytes} + (BYTE_W + 1)'(3);
    assign w_start_units = CMP_W'(w_start_sum[BYTE_W:2]);
    assign w_end_units   = CMP_W'(w_end_sum[BYTE_W:2]);
    assign w_need        = (i_request_bytes <= ONE_UNIT_MAX) ? CMP_W'(1)
                                                             : CMP_W'(w_req_sum[BYTE_W:2]);
    assign w_free_unit   = CMP_W'(i_free_address[BYTE_W-1:2]);
    assign w_idx_ext     = CMP_W'(r_idx);
    assign w_run_inc     = CMP_W'(r_run) + CMP_W'(1);
    assign w_issue_done  = (r_idx == UNIT_CW'(UNIT_COUNT));
    assign w_rd_code     = t_code'(r_rdata);
    assign w_free_seen   = r_pend && (w_rd_code == CODE_FREE);
    assign w_hit         = w_free_seen && (w_run_inc == r_need);
    assign w_hit_start   = (r_run == '0) ? r_pidx : r_start;
    assign w_mark_last   = (r_idx[UNIT_AW-1:0] == r_last);
    assign w_init_code   = ((w_idx_ext < w_start_units) || (w_idx_ext >= w_end_units))
                           ? CODE_RSVD : CODE_FREE;

    always_comb begin
        w_we    = 1'b0;
        w_wdata = CODE_FREE;
        if (i_cmd.clear_wr || i_cmd.free_wr) begin
            w_we    = 1'b1;
            w_wdata = CODE_FREE;
        end else if (i_cmd.init_wr) begin
            w_we    = 1'b1;
            w_wdata = w_init_code;
        end else if (i_cmd.mark) begin
            w_we    = 1'b1;
            w_wdata = w_mark_last ? CODE_END : CODE_CONT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_idx[UNIT_AW-1:0]] <= w_wdata;
        end
        r_rdata <= r_mem[r_idx[UNIT_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_halted  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx <= (t_action'(i_action) == ACT_FREE) ? w_free_unit[UNIT_CW-1:0] : '0;
            end else if (w_we) begin
                r_idx <= r_idx + UNIT_CW'(1);
            end else if (i_cmd.scan) begin
                if (w_hit) begin
                    r_idx <= UNIT_CW'(w_hit_start);
                end else if (!w_issue_done) begin
                    r_idx <= r_idx + UNIT_CW'(1);
                end
            end
            r_pend <= i_cmd.scan && !w_hit && !w_issue_done;
            if (i_cmd.set_halt) begin
                r_halted <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_need <= w_need;
            r_run  <= '0;
        end else if (i_cmd.scan && r_pend) begin
            if (w_rd_code == CODE_FREE) begin
                r_run <= r_run + UNIT_CW'(1);
                if (r_run == '0) begin
                    r_start <= r_pidx;
                end
            end else begin
                r_run <= '0;
            end
            if (w_hit) begin
                r_last <= r_pidx;
            end
        end
        r_pidx <= r_idx[UNIT_AW-1:0];
        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res_code;
            r_res_addr   <= i_cmd.res_addr ? BYTE_W'({r_start, 2'b00}) : '0;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_addr   <= r_res_addr;
        end
    end

    assign o_stat.halted    = r_halted;
    assign o_stat.bad_init  = (i_heap_end < i_heap_start);
    assign o_stat.free_oob  = (w_free_unit >= CMP_W'(UNIT_COUNT));
    assign o_stat.idx_last  = (r_idx == UNIT_CW'(UNIT_COUNT - 1));
    assign o_stat.hit       = w_hit;
    assign o_stat.scan_end  = w_issue_done && !r_pend;
    assign o_stat.mark_last = w_mark_last;
    assign o_stat.rd_code   = w_rd_code;
    assign o_stat.out_free  = !r_out_vld || i_out_ready;

    assign o_out_valid     = r_out_vld;
    assign o_status        = r_out_status;
    assign o_block_address = r_out_addr;

endmodule

[hdl/ffca_ctrl.sv]
// Sequencing state machine for clear, init, allocate and free passes.
module ffca_ctrl import ffca_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic [1:0] i_action,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_MARK,
        S_FREAD,
        S_FCHK,
        S_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_first;
    logic   n_first;

    always_comb begin
        n_state = r_state;
        n_first = r_first;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.halted) begin
                        o_cmd.set_res  = 1'b1;
                        o_cmd.res_code = STAT_HALTED;
                        n_state        = S_RESULT;
                    end else begin
                        case (t_action'(i_action))
                            ACT_INIT: begin
                                if (i_stat.bad_init) begin
                                    o_cmd.set_res  = 1'b1;
                                    o_cmd.res_code = STAT_BADINIT;
                                    n_state        = S_RESULT;
                                end else begin
                                    n_state = S_INIT;
                                end
                            end
                            ACT_ALLOC: begin
                                n_state = S_SCAN;
                            end
                            ACT_FREE: begin
                                if (i_stat.free_oob) begin
                                    o_cmd.set_halt = 1'b1;
                                    o_cmd.set_res  = 1'b1;
                                    o_cmd.res_code = STAT_NOTALLOC;
                                    n_state        = S_RESULT;
                                end else begin
                                    n_first = 1'b1;
                                    n_state = S_FREAD;
                                end
                            end
                            default: begin
                                o_cmd.set_res  = 1'b1;
                                o_cmd.res_code = STAT_OK;
                                n_state        = S_RESULT;
                            end
                        endcase
                    end
                end
            end
            S_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_stat.idx_last) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = STAT_OK;
                    n_state        = S_RESULT;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.hit) begin
                    n_state = S_MARK;
                end else if (i_stat.scan_end) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = STAT_NOSPACE;
                    n_state        = S_RESULT;
                end
            end
            S_MARK: begin
                o_cmd.mark = 1'b1;
                if (i_stat.mark_last) begin
                    o_cmd.set_res  = 1'b1;
                    o_cmd.res_code = STAT_OK;
                    o_cmd.res_addr = 1'b1;
                    n_state        = S_RESULT;
                end
            end
            S_FREAD: begin
                n_state = S_FCHK;
            end
            S_FCHK: begin
                n_first = 1'b0;
                case (i_stat.rd_code)
                    CODE_END: begin
                        o_cmd.free_wr  = 1'b1;
                        o_cmd.set_res  = 1'b1;
                        o_cmd.res_code = STAT_OK;
                        n_state        = S_RESULT;
                    end
                    CODE_CONT: begin
                        o_cmd.free_wr = 1'b1;
                        if (i_stat.idx_last) begin
                            o_cmd.set_halt = 1'b1;
                            o_cmd.set_res  = 1'b1;
                            o_cmd.res_code = STAT_UNTERM;
                            n_state        = S_RESULT;
                        end else begin
                            n_state = S_FREAD;
                        end
                    end
                    default: begin
                        o_cmd.set_halt = 1'b1;
                        o_cmd.set_res  = 1'b1;
                        o_cmd.res_code = r_first ? STAT_NOTALLOC : STAT_UNTERM;
                        n_state        = S_RESULT;
                    end
                endcase
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

[hdl/first_fit_cluster_allocator_top.sv]
// Passes: init sweeps every unit; allocate scans for a free run, then marks it; free walks the chain.
// Throughput: one request at a time; the single-port unit table paces every scan and sweep.
// A finished result sits in the output register while the next request is taken.
// Reset: synchronous active low; a clearing sweep then frees every unit,
// with no request taken until it ends (register writes still taken).
// Top level of the first-fit cluster allocator: register port, controller and datapath.
module first_fit_cluster_allocator_top import ffca_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_action,
    input  logic [BYTE_W-1:0] i_request_bytes,
    input  logic [BYTE_W-1:0] i_free_address,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_status,
    output logic [BYTE_W-1:0] o_block_address,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    logic [BYTE_W-1:0] r_heap_start;
    logic [BYTE_W-1:0] r_heap_end;
    t_dp_cmd           w_cmd;
    t_dp_stat          w_stat;
    t_reg              w_reg;

    assign pready = 1'b1;
    assign w_reg  = t_reg'(paddr[CFG_AW-1]);
    assign prdata = (w_reg == REG_HEAP_END) ? CFG_DW'(r_heap_end) : CFG_DW'(r_heap_start);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_start <= '0;
            r_heap_end   <= HEAP_END_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (w_reg)
                REG_HEAP_START: r_heap_start <= pwdata[BYTE_W-1:0];
                REG_HEAP_END:   r_heap_end   <= pwdata[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ffca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ffca_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_action        (i_action),
        .i_request_bytes (i_request_bytes),
        .i_free_address  (i_free_address),
        .i_heap_start    (r_heap_start),
        .i_heap_end      (r_heap_end),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_block_address (o_block_address)
    );

`ifndef SYNTHESIS
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while previous request in progress");

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.halted |=> w_stat.halted)
        else $error("halt flag dropped without reset");

    a_addr_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != STAT_OK)) |-> (o_block_address == '0))
        else $error("nonzero block address on failed request");
`endif

endmodule
